FILE: hw/rtl/rotated_segment_endpoints_defines.svh
// assertion macros for the rotated segment endpoints block
// no dependencies; included by the top level
`ifndef ROTATED_SEGMENT_ENDPOINTS_DEFINES_SVH
`define ROTATED_SEGMENT_ENDPOINTS_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define RSE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define RSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/rse_pkg.sv
// package for the rotated segment endpoints block: beat types, constants, atan table
// no dependencies
package rse_pkg;

    localparam int unsigned CordicStagesDef = 16;
    localparam int unsigned CordicMax       = 24;

    // register indexes
    localparam logic [1:0] RegLengthRatio  = 2'd0;
    localparam logic [1:0] RegOffsetX      = 2'd1;
    localparam logic [1:0] RegOffsetYRatio = 2'd2;

    typedef struct packed {
        logic signed [23:0] anchor_x;
        logic signed [23:0] anchor_y;
        logic        [15:0] turn_angle;
        logic        [22:0] body_height;
    } t_in_beat;

    typedef struct packed {
        logic signed [23:0] front_x;
        logic signed [23:0] front_y;
        logic signed [23:0] rear_x;
        logic signed [23:0] rear_y;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
    } t_out_beat;

    // pipeline flow control shared by the stage modules
    typedef struct packed {
        logic adv;
    } t_pipe_ctl;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;  5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;  5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;  5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;  5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;  5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;  5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;  5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;  5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;  5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

FILE: hw/rtl/rse_cordic.sv
// pipelined rotation-mode cordic: one micro-rotation per register stage
// depends on rse_pkg
module rse_cordic
    import rse_pkg::*;
#(
    parameter int unsigned STAGES = CordicStagesDef
) (
    input  logic               i_clk,
    input  t_pipe_ctl          i_ctl,
    input  logic        [15:0] i_angle,
    output logic signed [15:0] o_cos,
    output logic signed [15:0] o_sin
);
    localparam int unsigned N = (STAGES > CordicMax) ? CordicMax : STAGES;

    logic signed [33:0] r_x [0:N];
    logic signed [33:0] r_y [0:N];
    logic signed [33:0] r_z [0:N];
    logic        [1:0]  r_q [0:N];
    logic signed [33:0] r_c, r_s;

    logic [31:0] ang;
    logic [1:0]  q0;
    logic [31:0] d0;

    // quadrant reduction
    always_comb begin
        ang = {i_angle, 16'h0};
        q0  = 2'((ang + 32'h20000000) >> 30);
        d0  = ang - {q0, 30'h0};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_x[0] <= 34'sh026DD3B6A;
            r_y[0] <= '0;
            r_z[0] <= 34'(signed'(d0));
            r_q[0] <= q0;
        end
    end

    // micro-rotation stages
    for (genvar g = 0; g < N; g++) begin : g_stage
        logic signed [33:0] xs, ys, at;
        assign xs = r_x[g] >>> g;
        assign ys = r_y[g] >>> g;
        assign at = 34'(signed'({1'b0, atan_turn(5'(g))}));
        always_ff @(posedge i_clk) begin
            if (i_ctl.adv) begin
                r_q[g+1] <= r_q[g];
                if (!r_z[g][33]) begin
                    r_x[g+1] <= r_x[g] - ys;
                    r_y[g+1] <= r_y[g] + xs;
                    r_z[g+1] <= r_z[g] - at;
                end else begin
                    r_x[g+1] <= r_x[g] + ys;
                    r_y[g+1] <= r_y[g] - xs;
                    r_z[g+1] <= r_z[g] + at;
                end
            end
        end
    end

    // quadrant fix-up
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            case (r_q[N])
                2'd1:    begin r_c <= -r_y[N]; r_s <= r_x[N];  end
                2'd2:    begin r_c <= -r_x[N]; r_s <= -r_y[N]; end
                2'd3:    begin r_c <= r_y[N];  r_s <= -r_x[N]; end
                default: begin r_c <= r_x[N];  r_s <= r_y[N];  end
            endcase
        end
    end

    // round to q1.14 and clamp
    function automatic logic signed [15:0] rnd(input logic signed [33:0] v);
        logic signed [33:0] t;
        t = (v + 34'sd32768) >>> 16;
        if (t > 34'sd16384)       return 16'sd16384;
        else if (t < -34'sd16384) return -16'sd16384;
        else                      return t[15:0];
    endfunction

    assign o_cos = rnd(r_c);
    assign o_sin = rnd(r_s);
endmodule

FILE: hw/rtl/rse_geom.sv
// local segment geometry pipeline: half length, centre y, front and rear y, zero-length flag
// depends on rse_pkg
module rse_geom
    import rse_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic               i_clk,
    input  t_pipe_ctl          i_ctl,
    input  logic        [22:0] i_height,
    input  logic        [15:0] i_len_ratio,
    input  logic signed [15:0] i_oy_ratio,
    output logic signed [25:0] o_fy,
    output logic signed [25:0] o_ry,
    output logic               o_zero
);
    logic        [38:0] r_hl;
    logic signed [39:0] r_hy;
    logic signed [25:0] r_fy [0:DEPTH-1];
    logic signed [25:0] r_ry [0:DEPTH-1];
    logic               r_zero [0:DEPTH-1];
    logic        [24:0] half;
    logic signed [25:0] cy;

    // products
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_hl <= 39'(i_height) * 39'(i_len_ratio);
            r_hy <= $signed({17'b0, i_height}) * 40'(i_oy_ratio);
        end
    end

    assign half = 25'((r_hl + 39'd16384) >> 15);
    assign cy   = 26'((r_hy + 40'sd8192) >>> 14);

    // endpoints then delay line
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_fy[0]   <= cy - $signed({1'b0, half});
            r_ry[0]   <= cy + $signed({1'b0, half});
            r_zero[0] <= (r_hl == '0);
            for (int k = 1; k < DEPTH; k++) begin
                r_fy[k]   <= r_fy[k-1];
                r_ry[k]   <= r_ry[k-1];
                r_zero[k] <= r_zero[k-1];
            end
        end
    end

    assign o_fy   = r_fy[DEPTH-1];
    assign o_ry   = r_ry[DEPTH-1];
    assign o_zero = r_zero[DEPTH-1];
endmodule

FILE: hw/rtl/rse_rotate.sv
// rotate local endpoints, round, translate and saturate in a product stage and a sum stage
// depends on rse_pkg
module rse_rotate
    import rse_pkg::*;
(
    input  logic               i_clk,
    input  t_pipe_ctl          i_ctl,
    input  logic signed [15:0] i_cos,
    input  logic signed [15:0] i_sin,
    input  logic signed [23:0] i_lx,
    input  logic signed [25:0] i_fy,
    input  logic signed [25:0] i_ry,
    input  logic signed [23:0] i_ax,
    input  logic signed [23:0] i_ay,
    output logic signed [23:0] o_fx,
    output logic signed [23:0] o_fyo,
    output logic signed [23:0] o_rx,
    output logic signed [23:0] o_ryo
);
    // products of stage one
    logic signed [40:0] r_clx, r_slx, r_sfy, r_cfy, r_sry, r_cry;
    logic signed [23:0] r_ax, r_ay;
    logic signed [42:0] fx, fy, rx, ry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_clx <= 41'(i_cos * i_lx);
            r_slx <= 41'(i_sin * i_lx);
            r_sfy <= 41'(i_sin * i_fy);
            r_cfy <= 41'(i_cos * i_fy);
            r_sry <= 41'(i_sin * i_ry);
            r_cry <= 41'(i_cos * i_ry);
            r_ax  <= i_ax;
            r_ay  <= i_ay;
        end
    end

    function automatic logic signed [23:0] fin(input logic signed [41:0] v,
                                               input logic signed [23:0] a);
        logic signed [29:0] t;
        t = 30'((v + 42'sd8192) >>> 14) + 30'(a);
        if (t > 30'sd8388607)       return 24'sh7FFFFF;
        else if (t < -30'sd8388608) return 24'sh800000;
        else                        return t[23:0];
    endfunction

    assign fx = 43'(r_clx) - 43'(r_sfy);
    assign fy = 43'(r_slx) + 43'(r_cfy);
    assign rx = 43'(r_clx) - 43'(r_sry);
    assign ry = 43'(r_slx) + 43'(r_cry);

    // sums, round, saturate
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            o_fx  <= fin(42'(fx), r_ax);
            o_fyo <= fin(42'(fy), r_ay);
            o_rx  <= fin(42'(rx), r_ax);
            o_ryo <= fin(42'(ry), r_ay);
        end
    end
endmodule

FILE: hw/rtl/rotated_segment_endpoints.sv
// rotated segment endpoints: an input beat passes the cordic input register, the micro-rotation
// stages (stage count capped at 24), the fix-up stage, then the product and sum stages
// throughput one beat per cycle unless the output stalls, set by the cordic micro-rotation pipeline
// the whole pipeline holds while the output is stalled and a beat waits there
// reset clears valid bits and restores the configuration registers to their reset values
// depends on rse_pkg, rse_cordic, rse_geom, rse_rotate, the defines header
`include "rotated_segment_endpoints_defines.svh"
module rotated_segment_endpoints
    import rse_pkg::*;
#(
    parameter int unsigned CORDIC_STAGES = CordicStagesDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in_beat    i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_beat   o_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int unsigned N   = (CORDIC_STAGES > CordicMax) ? CordicMax : CORDIC_STAGES;
    localparam int unsigned LAT = N + 4;
    localparam int unsigned RL  = N + 2;

    logic [15:0]        r_len_ratio;
    logic signed [23:0] r_off_x;
    logic signed [15:0] r_oy_ratio;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_ratio <= 16'd16384;
            r_off_x     <= '0;
            r_oy_ratio  <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                RegLengthRatio:  r_len_ratio <= pwdata[15:0];
                RegOffsetX:      r_off_x     <= pwdata[23:0];
                RegOffsetYRatio: r_oy_ratio  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            RegLengthRatio:  prdata = {16'h0, r_len_ratio};
            RegOffsetX:      prdata = {{8{r_off_x[23]}}, r_off_x};
            RegOffsetYRatio: prdata = {{16{r_oy_ratio[15]}}, r_oy_ratio};
            default:         prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    // pipeline advances unless a finished beat is held
    t_pipe_ctl ctl;
    logic [LAT-1:0] r_vld;
    assign ctl.adv = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !ctl.adv;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ctl.adv) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // anchor delay line to the rotate stage
    logic signed [23:0] r_ax [0:RL-1];
    logic signed [23:0] r_ay [0:RL-1];
    always_ff @(posedge i_clk) begin
        if (ctl.adv) begin
            r_ax[0] <= i_data.anchor_x;
            r_ay[0] <= i_data.anchor_y;
            for (int k = 1; k < RL; k++) begin
                r_ax[k] <= r_ax[k-1];
                r_ay[k] <= r_ay[k-1];
            end
        end
    end

    logic signed [15:0] cosv, sinv;
    logic signed [25:0] fy, ry;
    logic               zero;

    rse_cordic #(.STAGES(N)) u_cordic (
        .i_clk(i_clk), .i_ctl(ctl), .i_angle(i_data.turn_angle),
        .o_cos(cosv), .o_sin(sinv)
    );

    // geometry lines up with the cordic output after its fix-up stage
    rse_geom #(.DEPTH(N + 1)) u_geom (
        .i_clk(i_clk), .i_ctl(ctl), .i_height(i_data.body_height),
        .i_len_ratio(r_len_ratio), .i_oy_ratio(r_oy_ratio),
        .o_fy(fy), .o_ry(ry), .o_zero(zero)
    );

    logic signed [23:0] fx_o, fy_o, rx_o, ry_o;
    rse_rotate u_rot (
        .i_clk(i_clk), .i_ctl(ctl), .i_cos(cosv), .i_sin(sinv), .i_lx(r_off_x),
        .i_fy(fy), .i_ry(ry), .i_ax(r_ax[RL-1]), .i_ay(r_ay[RL-1]),
        .o_fx(fx_o), .o_fyo(fy_o), .o_rx(rx_o), .o_ryo(ry_o)
    );

    // direction, delayed alongside the rotate stage
    logic signed [15:0] r_dx [0:1];
    logic signed [15:0] r_dy [0:1];
    always_ff @(posedge i_clk) begin
        if (ctl.adv) begin
            r_dx[0] <= zero ? 16'sd0 : sinv;
            r_dy[0] <= zero ? -16'sd16384 : -cosv;
            r_dx[1] <= r_dx[0];
            r_dy[1] <= r_dy[0];
        end
    end

    assign o_data.front_x = fx_o;
    assign o_data.front_y = fy_o;
    assign o_data.rear_x  = rx_o;
    assign o_data.rear_y  = ry_o;
    assign o_data.dir_x   = r_dx[1];
    assign o_data.dir_y   = r_dy[1];

    `RSE_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data), "held beat changed")
    `RSE_ASSERT_IMPL(a_stall, i_clk, i_rst_n, o_stall, o_valid && i_stall, "stall without held beat")
    `RSE_ASSERT_IMPL(a_dir, i_clk, i_rst_n, o_valid, o_data.dir_y <= 16'sd16384 && o_data.dir_y >= -16'sd16384, "dir out of range")
endmodule

FILE: tb/sv/testbench.sv
// testbench for rotated_segment_endpoints: random and directed beats checked
// against an in-bench fixed-point model of the rotate-and-translate math
// depends on rse_pkg and the rotated_segment_endpoints rtl
module testbench;
    import rse_pkg::*;

    localparam int unsigned STAGES = 16;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_in_beat    i_data;
    logic        o_valid;
    logic        i_stall;
    t_out_beat   o_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rotated_segment_endpoints #(.CORDIC_STAGES(STAGES)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // shadow copy of the registers
    logic [15:0]        cfg_len_ratio;
    logic signed [23:0] cfg_off_x;
    logic signed [15:0] cfg_off_y_ratio;

    t_in_beat  pending_beats[$];
    t_out_beat expected_points[$];
    int        send_idle_pct;
    int        recv_idle_pct;
    int        hold_off_cycles;
    int        n_errors;

    localparam logic [31:0] ATAN_TAB [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic longint clamp_val(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // rotate-mode cordic, quarter turn applied afterwards, result in q1.14
    task automatic cordic_sincos(input logic [15:0] angle, output longint c,
                                 output longint s);
        logic [31:0] ang;
        logic [31:0] q;
        logic [31:0] d;
        longint z;
        longint x;
        longint y;
        longint xs;
        longint ys;
        longint t;
        ang = {angle, 16'h0};
        q = (ang + 32'h20000000) >> 30;
        d = ang - (q << 30);
        z = longint'(signed'(d));
        x = 64'h26DD3B6A;
        y = 0;
        for (int i = 0; i < STAGES && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= longint'(ATAN_TAB[i]);
            end else begin
                x += ys; y -= xs; z += longint'(ATAN_TAB[i]);
            end
        end
        c = x; s = y;
        case (q[1:0])
            2'd1: begin t = c; c = -s; s = t; end
            2'd2: begin c = -c; s = -s; end
            2'd3: begin t = c; c = s; s = -t; end
            default: ;
        endcase
        c = clamp_val((c + 32768) >>> 16, -16384, 16384);
        s = clamp_val((s + 32768) >>> 16, -16384, 16384);
    endtask

    function automatic logic [23:0] place_coord(longint anchor, longint v);
        return 24'(clamp_val(anchor + ((v + 8192) >>> 14), -8388608, 8388607));
    endfunction

    task automatic predict_endpoints(input t_in_beat b);
        t_out_beat r;
        longint ax;
        longint ay;
        longint hl;
        longint half;
        longint cy;
        longint lx;
        longint fy;
        longint ry;
        longint c;
        longint s;
        ax = longint'(b.anchor_x);
        ay = longint'(b.anchor_y);
        hl = longint'(b.body_height) * longint'(cfg_len_ratio);
        half = (hl + 16384) >> 15;
        cy = (longint'(b.body_height) * longint'(cfg_off_y_ratio) + 8192) >>> 14;
        lx = longint'(cfg_off_x);
        fy = cy - half;
        ry = cy + half;
        cordic_sincos(b.turn_angle, c, s);
        r.front_x = place_coord(ax, c * lx - s * fy);
        r.front_y = place_coord(ay, s * lx + c * fy);
        r.rear_x  = place_coord(ax, c * lx - s * ry);
        r.rear_y  = place_coord(ay, s * lx + c * ry);
        if (hl != 0) begin
            r.dir_x = 16'(s);
            r.dir_y = 16'(-c);
        end else begin
            r.dir_x = 16'sd0;
            r.dir_y = -16'sd16384;
        end
        expected_points.push_back(r);
    endtask

    // apb write, setup then access cycle
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            RegLengthRatio:  cfg_len_ratio = val[15:0];
            RegOffsetX:      cfg_off_x = val[23:0];
            RegOffsetYRatio: cfg_off_y_ratio = val[15:0];
            default: ;
        endcase
    endtask

    function automatic t_in_beat rand_beat();
        t_in_beat b;
        b.anchor_x = 24'($urandom);
        b.anchor_y = 24'($urandom);
        b.turn_angle = 16'($urandom);
        case ($urandom_range(0, 3))
            0: b.body_height = 23'($urandom);
            1: b.body_height = 23'($urandom_range(0, 255));
            default: b.body_height = 23'($urandom_range(0, 65535));
        endcase
        if ($urandom_range(0, 3) != 0) begin
            b.anchor_x = 24'($signed(b.anchor_x) >>> 6);
            b.anchor_y = 24'($signed(b.anchor_y) >>> 6);
        end
        return b;
    endfunction

    function automatic t_in_beat mk_beat(logic [23:0] ax, logic [23:0] ay,
                                         logic [15:0] ang, logic [22:0] h);
        t_in_beat b;
        b.anchor_x = ax; b.anchor_y = ay; b.turn_angle = ang; b.body_height = h;
        return b;
    endfunction

    // wait for the pipeline to drain before touching registers
    task automatic drain();
        while (pending_beats.size() != 0 || expected_points.size() != 0 || i_valid)
            @(posedge i_clk);
        repeat (STAGES + 10) @(posedge i_clk);
    endtask

    task automatic random_phase(input int n);
        for (int k = 0; k < n; k++) pending_beats.push_back(rand_beat());
    endtask

    // driver: one beat offered at a time, held while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) predict_endpoints(i_data);
            if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_data <= pending_beats.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with a long hold-off when asked
    always @(posedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // monitor: compare each output beat with the oldest expectation
    always @(posedge i_clk) begin
        t_out_beat e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_points.size() == 0) begin
                $error("output beat with nothing expected");
                n_errors++;
            end else begin
                e = expected_points.pop_front();
                if (o_data.front_x !== e.front_x) begin
                    $error("front_x exp %0d got %0d", e.front_x, o_data.front_x);
                    n_errors++;
                end
                if (o_data.front_y !== e.front_y) begin
                    $error("front_y exp %0d got %0d", e.front_y, o_data.front_y);
                    n_errors++;
                end
                if (o_data.rear_x !== e.rear_x) begin
                    $error("rear_x exp %0d got %0d", e.rear_x, o_data.rear_x);
                    n_errors++;
                end
                if (o_data.rear_y !== e.rear_y) begin
                    $error("rear_y exp %0d got %0d", e.rear_y, o_data.rear_y);
                    n_errors++;
                end
                if (o_data.dir_x !== e.dir_x) begin
                    $error("dir_x exp %0d got %0d", e.dir_x, o_data.dir_x);
                    n_errors++;
                end
                if (o_data.dir_y !== e.dir_y) begin
                    $error("dir_y exp %0d got %0d", e.dir_y, o_data.dir_y);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        int wait_cycles;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_data = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        cfg_len_ratio = 16'd16384;
        cfg_off_x = '0;
        cfg_off_y_ratio = '0;
        send_idle_pct = 21;
        recv_idle_pct = 82;
        hold_off_cycles = 0;
        n_errors = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset registers, field extremes, quarter turns, zero length
        pending_beats.push_back(mk_beat(24'h0, 24'h0, 16'h0000, 23'h0));
        pending_beats.push_back(mk_beat(24'h7FFFFF, 24'h7FFFFF, 16'h4000, 23'h7FFFFF));
        pending_beats.push_back(mk_beat(24'h800000, 24'h800000, 16'h8000, 23'h7FFFFF));
        pending_beats.push_back(mk_beat(24'h000100, 24'hFFFF00, 16'hC000, 23'h000100));
        pending_beats.push_back(mk_beat(24'h0, 24'h0, 16'hFFFF, 23'h001000));
        pending_beats.push_back(mk_beat(24'h0, 24'h0, 16'h2000, 23'h001000));
        pending_beats.push_back(mk_beat(24'h0, 24'h0, 16'h1FFF, 23'h001000));
        pending_beats.push_back(mk_beat(24'h0, 24'h0, 16'hE000, 23'h000001));
        drain();

        // extreme registers: saturation and zero-length via ratio
        write_reg(RegLengthRatio, 32'h0000FFFF);
        write_reg(RegOffsetX, 32'h007FFFFF);
        write_reg(RegOffsetYRatio, 32'h00007FFF);
        pending_beats.push_back(mk_beat(24'h7FFFFF, 24'h7FFFFF, 16'h0000, 23'h7FFFFF));
        pending_beats.push_back(mk_beat(24'h800000, 24'h800000, 16'h6000, 23'h7FFFFF));
        pending_beats.push_back(mk_beat(24'h0, 24'h0, 16'hA000, 23'h000200));
        random_phase(150);
        drain();
        write_reg(RegLengthRatio, 32'h0);
        write_reg(RegOffsetX, 32'h00800000);
        write_reg(RegOffsetYRatio, 32'h00008000);
        pending_beats.push_back(mk_beat(24'h0, 24'h0, 16'h4000, 23'h7FFFFF));
        pending_beats.push_back(mk_beat(24'h800000, 24'h7FFFFF, 16'h8000, 23'h000001));
        random_phase(150);
        drain();

        // other way round: sender mostly idle, receiver mostly ready
        send_idle_pct = 82;
        recv_idle_pct = 21;
        write_reg(RegLengthRatio, $urandom);
        write_reg(RegOffsetX, $urandom);
        write_reg(RegOffsetYRatio, $urandom);
        random_phase(250);
        drain();

        // no idling, then a long receiver hold-off to fill the pipeline
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(RegLengthRatio, 32'd16384);
        write_reg(RegOffsetX, $urandom_range(0, 4095));
        write_reg(RegOffsetYRatio, 32'hFFFFC000);
        hold_off_cycles = 200;
        random_phase(250);
        drain();
        write_reg(RegLengthRatio, $urandom);
        write_reg(RegOffsetX, $urandom);
        write_reg(RegOffsetYRatio, $urandom);
        random_phase(230);
        drain();

        wait_cycles = 0;
        while (expected_points.size() != 0 && wait_cycles < 10000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        if (n_errors == 0 && expected_points.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

FILE: rotated_segment_endpoints.f
+incdir+hw/rtl
hw/rtl/rse_pkg.sv
hw/rtl/rse_cordic.sv
hw/rtl/rse_geom.sv
hw/rtl/rse_rotate.sv
hw/rtl/rotated_segment_endpoints.sv
tb/sv/testbench.sv
